// ===== design/slt_pkg.sv =====
// slt_pkg: shared constants, token and error codes, result record and
// character class / keyword helpers for the source lexer tokenizer
// no dependencies
package slt_pkg;

   localparam int MAX_LEXEME     = 64;
   localparam int KEYWORD_CHARS  = 5;
   localparam int POSITION_WIDTH = 16;

   localparam int LEN_WIDTH  = $clog2(MAX_LEXEME + 1);
   localparam int KBUF_WIDTH = 8 * KEYWORD_CHARS;
   localparam int NUM_KW     = 9;

   typedef logic [POSITION_WIDTH-1:0] pos_type;
   typedef logic [LEN_WIDTH-1:0]      len_type;
   typedef logic [KBUF_WIDTH-1:0]     kbuf_type;
   typedef logic [4:0]                kind_type;
   typedef logic [2:0]                err_type;

   localparam pos_type POS_MAX = {POSITION_WIDTH{1'b1}};

   // token kinds
   localparam kind_type K_EOF    = 5'd0;
   localparam kind_type K_ID     = 5'd1;
   localparam kind_type K_INT    = 5'd2;
   localparam kind_type K_FLOAT  = 5'd3;
   localparam kind_type K_CHAR   = 5'd4;
   localparam kind_type K_PLUS   = 5'd5;
   localparam kind_type K_MINUS  = 5'd6;
   localparam kind_type K_STAR   = 5'd7;
   localparam kind_type K_DIV    = 5'd8;
   localparam kind_type K_ASSIGN = 5'd9;
   localparam kind_type K_EQEQ   = 5'd10;
   localparam kind_type K_LT     = 5'd11;
   localparam kind_type K_LE     = 5'd12;
   localparam kind_type K_GT     = 5'd13;
   localparam kind_type K_GE     = 5'd14;
   localparam kind_type K_NE     = 5'd15;
   localparam kind_type K_LPAR   = 5'd16;
   localparam kind_type K_RPAR   = 5'd17;
   localparam kind_type K_LBRACE = 5'd18;
   localparam kind_type K_RBRACE = 5'd19;
   localparam kind_type K_SEMI   = 5'd20;
   localparam kind_type K_COMMA  = 5'd21;
   localparam kind_type K_MAIN   = 5'd22;
   localparam kind_type K_IF     = 5'd23;
   localparam kind_type K_ELSE   = 5'd24;
   localparam kind_type K_KWINT  = 5'd25;
   localparam kind_type K_KWFLT  = 5'd26;
   localparam kind_type K_KWCHAR = 5'd27;
   localparam kind_type K_WHILE  = 5'd28;
   localparam kind_type K_DO     = 5'd29;
   localparam kind_type K_FOR    = 5'd30;
   localparam kind_type K_ERROR  = 5'd31;

   // error codes
   localparam err_type E_NONE      = 3'd0;
   localparam err_type E_BAD_FLOAT = 3'd1;
   localparam err_type E_BAD_CHAR  = 3'd2;
   localparam err_type E_INVALID   = 3'd3;
   localparam err_type E_OPEN_COM  = 3'd4;
   localparam err_type E_BAD_BANG  = 3'd5;

   // keyword table, text right aligned (first char in the upper byte)
   localparam kbuf_type KW_TEXT [NUM_KW] = '{
      kbuf_type'("main"), kbuf_type'("if"), kbuf_type'("else"),
      kbuf_type'("int"), kbuf_type'("float"), kbuf_type'("char"),
      kbuf_type'("while"), kbuf_type'("do"), kbuf_type'("for")};
   localparam int KW_LEN [NUM_KW] = '{4, 2, 4, 3, 5, 4, 5, 2, 3};
   localparam kind_type KW_KIND [NUM_KW] = '{
      K_MAIN, K_IF, K_ELSE, K_KWINT, K_KWFLT, K_KWCHAR, K_WHILE, K_DO, K_FOR};

   typedef struct packed {
      kind_type kind;
      err_type  err;
      pos_type  line;
      pos_type  column;
      len_type  length;
      logic     last;
   } result_type;

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // store a byte in the keyword buffer while the lexeme is still short
   function automatic kbuf_type kbuf_append(kbuf_type kb, len_type n, logic [7:0] c);
      kbuf_type r;
      r = kb;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         if (n == len_type'(i)) begin
            r[8*i +: 8] = c;
         end
      end
      return r;
   endfunction

   function automatic len_type len_inc(len_type n);
      return (n < len_type'(MAX_LEXEME)) ? len_type'(n + 1'b1) : n;
   endfunction

   function automatic kind_type keyword_kind(kbuf_type kb, len_type n);
      kind_type k;
      logic     same;
      int       j;
      k = K_ID;
      for (int w = NUM_KW - 1; w >= 0; w--) begin
         same = (n == len_type'(KW_LEN[w]));
         for (int i = 0; i < KEYWORD_CHARS; i++) begin
            j = KW_LEN[w] - 1 - i;
            if ((j >= 0) && (kb[8*i +: 8] != KW_TEXT[w][8*j +: 8])) begin
               same = 1'b0;
            end
         end
         if (same) begin
            k = KW_KIND[w];
         end
      end
      return k;
   endfunction

endpackage

// ===== design/source_lexer_tokenizer.sv =====
// source_lexer_tokenizer: one source byte per transaction in, tokens out
// depends on slt_pkg (codes, result record, character and keyword helpers)
//
// tokens are registered in the result queue before they reach the result port
// throughput: one byte per cycle while the input is ready; a byte that closes one token
//   and yields a second pushes two results, absorbed by the four-entry result queue
// the input is ready while the queue has room for two results
// synchronous active-high reset: scanner idle, line 1, column 0, tab width 4,
//   result queue empty
module source_lexer_tokenizer (
   input  logic                           clock,
   input  logic                           reset,
   // byte channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_end_of_input,
   // token channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [4:0]                     rsp_token_kind,
   output logic [2:0]                     rsp_error_code,
   output logic [slt_pkg::POSITION_WIDTH-1:0] rsp_token_line,
   output logic [slt_pkg::POSITION_WIDTH-1:0] rsp_token_column,
   output logic [slt_pkg::LEN_WIDTH-1:0]  rsp_lexeme_length,
   output logic                           rsp_last_of_run,
   // tab width register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [3:0]                     csr_tab_width
);

   typedef enum logic [4:0] {
      S_IDLE, S_IDENT, S_INT, S_FRAC0, S_FRAC, S_CHAR0, S_CHAR1, S_SLASH,
      S_LCOM, S_BCOM, S_BSTAR, S_EQ, S_LT, S_GT, S_BANG
   } scan_state_type;

   localparam int QDEPTH = 4;
   localparam int QIDX   = $clog2(QDEPTH);
   localparam int QCNT   = $clog2(QDEPTH + 1);

   // scanner state
   scan_state_type             state_ff, state_in;
   slt_pkg::pos_type           line_ff, line_in;
   slt_pkg::pos_type           col_ff, col_in;
   slt_pkg::kbuf_type          kbuf_ff, kbuf_in;
   slt_pkg::len_type           lcnt_ff, lcnt_in;
   slt_pkg::pos_type           sline_ff, sline_in;
   slt_pkg::pos_type           scol_ff, scol_in;
   logic [3:0]                 tab_ff;

   // result queue
   slt_pkg::result_type        queue_ff [QDEPTH];
   logic [QIDX-1:0]            head_ff, tail_ff;
   logic [QCNT-1:0]            count_ff;

   // up to two results per byte: a flushed pending token, then a second one
   slt_pkg::result_type        res_a, res_b;
   logic                       a_valid, b_valid;

   logic                       accept, pop;
   logic [7:0]                 c;
   logic                       taken;
   logic [POSITION_WIDTH_P1-1:0] col_sum;

   localparam int POSITION_WIDTH_P1 = slt_pkg::POSITION_WIDTH + 1;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= QCNT'(QDEPTH - 2));
   assign csr_ready = 1'b1;
   assign rsp_valid = (count_ff != '0);
   assign c         = req_char_code;

   assign rsp_token_kind    = queue_ff[head_ff].kind;
   assign rsp_error_code    = queue_ff[head_ff].err;
   assign rsp_token_line    = queue_ff[head_ff].line;
   assign rsp_token_column  = queue_ff[head_ff].column;
   assign rsp_lexeme_length = queue_ff[head_ff].length;
   assign rsp_last_of_run   = queue_ff[head_ff].last;

   // next-state and result logic for one byte
   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      kbuf_in  = kbuf_ff;
      lcnt_in  = lcnt_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      res_a    = '0;
      res_b    = '0;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      taken    = 1'b0;
      col_sum  = '0;

      // position update comes first: a byte's column is the one after itself
      if (!req_end_of_input) begin
         if (c == 8'h0A) begin
            col_in = '0;
            if (line_ff != slt_pkg::POS_MAX) begin
               line_in = line_ff + 1'b1;
            end
         end else begin
            col_sum = {1'b0, col_ff} + ((c == 8'h09) ? POSITION_WIDTH_P1'(tab_ff)
                                                     : POSITION_WIDTH_P1'(1));
            col_in  = col_sum[slt_pkg::POSITION_WIDTH] ? slt_pkg::POS_MAX
                                                       : col_sum[slt_pkg::POSITION_WIDTH-1:0];
         end
      end

      // continue the token under scan
      if (!req_end_of_input) begin
         case (state_ff)
            S_IDENT: begin
               if (slt_pkg::is_letter(c) || slt_pkg::is_digit(c) || (c == "_")) begin
                  taken = 1'b1;
               end
            end
            S_INT: begin
               if (slt_pkg::is_digit(c)) begin
                  taken = 1'b1;
               end else if (c == ".") begin
                  taken    = 1'b1;
                  state_in = S_FRAC0;
               end
            end
            S_FRAC0: begin
               if (slt_pkg::is_digit(c)) begin
                  taken    = 1'b1;
                  state_in = S_FRAC;
               end
            end
            S_FRAC: begin
               if (slt_pkg::is_digit(c)) begin
                  taken = 1'b1;
               end
            end
            S_CHAR0: begin
               if (slt_pkg::is_letter(c) || slt_pkg::is_digit(c)) begin
                  taken    = 1'b1;
                  state_in = S_CHAR1;
               end
            end
            S_CHAR1: begin
               if (c == "'") begin
                  taken    = 1'b1;
                  state_in = S_IDLE;
                  b_valid  = 1'b1;
                  res_b    = '{slt_pkg::K_CHAR, slt_pkg::E_NONE, sline_ff, scol_ff,
                               slt_pkg::len_inc(lcnt_ff), 1'b0};
               end
            end
            S_SLASH: begin
               if (c == "/") begin
                  taken    = 1'b1;
                  state_in = S_LCOM;
               end else if (c == "*") begin
                  taken    = 1'b1;
                  state_in = S_BCOM;
               end
            end
            S_BCOM: begin
               taken = 1'b1;
               if (c == "*") begin
                  state_in = S_BSTAR;
               end
            end
            S_BSTAR: begin
               taken = 1'b1;
               if (c == "/") begin
                  state_in = S_IDLE;
               end else if (c != "*") begin
                  state_in = S_BCOM;
               end
            end
            S_EQ, S_LT, S_GT: begin
               if (c == "=") begin
                  taken    = 1'b1;
                  state_in = S_IDLE;
                  b_valid  = 1'b1;
                  res_b    = '{(state_ff == S_EQ) ? slt_pkg::K_EQEQ :
                               (state_ff == S_LT) ? slt_pkg::K_LE : slt_pkg::K_GE,
                               slt_pkg::E_NONE, sline_ff, scol_ff,
                               slt_pkg::len_inc(lcnt_ff), 1'b0};
               end
            end
            S_BANG: begin
               // the byte after a bang is always consumed
               taken    = 1'b1;
               state_in = S_IDLE;
               b_valid  = 1'b1;
               res_b    = '{(c == "=") ? slt_pkg::K_NE : slt_pkg::K_ERROR,
                            (c == "=") ? slt_pkg::E_NONE : slt_pkg::E_BAD_BANG,
                            sline_ff, scol_ff, slt_pkg::len_inc(lcnt_ff), 1'b0};
            end
            default: begin
            end
         endcase

         // the line comment keeps no lexeme and ends on newline
         if (state_ff == S_LCOM) begin
            taken = 1'b1;
            if (c == 8'h0A) begin
               state_in = S_IDLE;
            end
         end else if (taken) begin
            kbuf_in = slt_pkg::kbuf_append(kbuf_ff, lcnt_ff, c);
            lcnt_in = slt_pkg::len_inc(lcnt_ff);
         end
      end

      // byte does not belong to the pending token: complete that token
      if (!taken) begin
         a_valid = 1'b1;
         res_a   = '{slt_pkg::K_ERROR, slt_pkg::E_NONE, sline_ff, scol_ff, lcnt_ff, 1'b0};
         case (state_ff)
            S_IDENT:       res_a.kind = slt_pkg::keyword_kind(kbuf_ff, lcnt_ff);
            S_INT:         res_a.kind = slt_pkg::K_INT;
            S_FRAC0:       res_a.err  = slt_pkg::E_BAD_FLOAT;
            S_FRAC:        res_a.kind = slt_pkg::K_FLOAT;
            S_CHAR0:       res_a.err  = slt_pkg::E_BAD_CHAR;
            S_CHAR1:       res_a.err  = slt_pkg::E_INVALID;
            S_SLASH:       res_a.kind = slt_pkg::K_DIV;
            S_BCOM,
            S_BSTAR:       res_a.err  = slt_pkg::E_OPEN_COM;
            S_EQ:          res_a.kind = slt_pkg::K_ASSIGN;
            S_LT:          res_a.kind = slt_pkg::K_LT;
            S_GT:          res_a.kind = slt_pkg::K_GT;
            S_BANG:        res_a.err  = slt_pkg::E_BAD_BANG;
            default:       a_valid    = 1'b0;
         endcase
         state_in = S_IDLE;

         if (req_end_of_input) begin
            // eof token at the current position, position kept
            b_valid = 1'b1;
            res_b   = '{slt_pkg::K_EOF, slt_pkg::E_NONE, line_ff, col_ff, '0, 1'b0};
         end else if (!slt_pkg::is_space(c)) begin
            // start a new token with this byte
            sline_in = line_in;
            scol_in  = col_in;
            kbuf_in  = slt_pkg::kbuf_append('0, '0, c);
            lcnt_in  = slt_pkg::len_inc('0);
            res_b    = '{slt_pkg::K_ERROR, slt_pkg::E_NONE, line_in, col_in, lcnt_in, 1'b0};
            b_valid  = 1'b1;
            case (c) inside
               ["a":"z"], ["A":"Z"], "_": begin
                  state_in = S_IDENT;
                  b_valid  = 1'b0;
               end
               ["0":"9"]: begin
                  state_in = S_INT;
                  b_valid  = 1'b0;
               end
               ".": begin
                  state_in = S_FRAC0;
                  b_valid  = 1'b0;
               end
               "'": begin
                  state_in = S_CHAR0;
                  b_valid  = 1'b0;
               end
               "/": begin
                  state_in = S_SLASH;
                  b_valid  = 1'b0;
               end
               "=": begin
                  state_in = S_EQ;
                  b_valid  = 1'b0;
               end
               "<": begin
                  state_in = S_LT;
                  b_valid  = 1'b0;
               end
               ">": begin
                  state_in = S_GT;
                  b_valid  = 1'b0;
               end
               "!": begin
                  state_in = S_BANG;
                  b_valid  = 1'b0;
               end
               "+":     res_b.kind = slt_pkg::K_PLUS;
               "-":     res_b.kind = slt_pkg::K_MINUS;
               "*":     res_b.kind = slt_pkg::K_STAR;
               "(":     res_b.kind = slt_pkg::K_LPAR;
               ")":     res_b.kind = slt_pkg::K_RPAR;
               "{":     res_b.kind = slt_pkg::K_LBRACE;
               "}":     res_b.kind = slt_pkg::K_RBRACE;
               ";":     res_b.kind = slt_pkg::K_SEMI;
               ",":     res_b.kind = slt_pkg::K_COMMA;
               default: res_b.err  = slt_pkg::E_INVALID;
            endcase
         end
      end

      // last_of_run marks whichever result comes last for this byte
      if (b_valid) begin
         res_b.last = 1'b1;
      end else begin
         res_a.last = 1'b1;
      end
   end

   logic [1:0] push_n;
   assign push_n = accept ? (2'(a_valid) + 2'(b_valid)) : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         line_ff  <= slt_pkg::pos_type'(1);
         col_ff   <= '0;
         kbuf_ff  <= '0;
         lcnt_ff  <= '0;
         sline_ff <= slt_pkg::pos_type'(1);
         scol_ff  <= '0;
         tab_ff   <= 4'd4;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            tab_ff <= csr_tab_width;
         end
         if (accept) begin
            state_ff <= state_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            kbuf_ff  <= kbuf_in;
            lcnt_ff  <= lcnt_in;
            sline_ff <= sline_in;
            scol_ff  <= scol_in;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         tail_ff  <= tail_ff + QIDX'(push_n);
         count_ff <= count_ff + QCNT'(push_n) - QCNT'(pop);
      end
   end

   // result queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         if (a_valid) begin
            queue_ff[tail_ff] <= res_a;
            if (b_valid) begin
               queue_ff[QIDX'(tail_ff + 1'b1)] <= res_b;
            end
         end else if (b_valid) begin
            queue_ff[tail_ff] <= res_b;
         end
      end
   end

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT'(QDEPTH))
      else $error("result queue overflow");

   // end of input always leaves the scanner idle with an eof token queued
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_input) |=> (state_ff == S_IDLE) && (count_ff != '0))
      else $error("end of input not completed");

   // a newline returns the column to zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_end_of_input && (req_char_code == 8'h0A)) |=> (col_ff == '0))
      else $error("newline did not clear column");

   // every accepted byte that yields results ends its run with last_of_run
   assert property (@(posedge clock) disable iff (reset)
      (accept && (a_valid || b_valid)) |-> (b_valid ? res_b.last : res_a.last))
      else $error("run without final marker");

endmodule

// ===== dv/slt_token_checker.sv =====
`timescale 1ns / 100ps
// slt_token_checker: watches the byte, token and tab width channels of the tokenizer,
// predicts every token from the accepted bytes and compares field by field
// depends on slt_pkg for token kinds, error codes and field widths
module slt_token_checker
   import slt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_char_code,
   input  logic                      req_end_of_input,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [4:0]                rsp_token_kind,
   input  logic [2:0]                rsp_error_code,
   input  logic [POSITION_WIDTH-1:0] rsp_token_line,
   input  logic [POSITION_WIDTH-1:0] rsp_token_column,
   input  logic [LEN_WIDTH-1:0]      rsp_lexeme_length,
   input  logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [3:0]                csr_tab_width,
   output int                        mismatch_count,
   output int                        tokens_pending,
   output int                        tokens_checked,
   output logic [31:0]               kinds_seen
);

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef enum logic [3:0] {
      SC_IDLE, SC_IDENT, SC_INT, SC_DOT, SC_FRAC, SC_QUOTE, SC_CHBODY, SC_SLASH,
      SC_LINECOM, SC_BLKCOM, SC_BLKSTAR, SC_EQ, SC_LT, SC_GT, SC_BANG
   } scan_phase_e;

   typedef struct packed {
      kind_type kind;
      err_type  err;
      pos_type  line;
      pos_type  col;
      len_type  len;
      logic     last;
   } token_info_t;

   // scanner copy
   scan_phase_e sc;
   pos_type     cur_line, cur_col, tok_line, tok_col;
   kbuf_type    head_bytes;
   len_type     tok_len;
   logic [3:0]  tab_cols;

   token_info_t expected_tokens[$];
   token_info_t step_tokens[$];

   function automatic logic letter_byte(logic [7:0] c);
      return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
   endfunction

   function automatic logic digit_byte(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic blank_byte(logic [7:0] c);
      return (c == " ") || ((c >= CH_TAB) && (c <= 8'h0D));
   endfunction

   // keywords are at most five bytes, all held in the head buffer
   function automatic kind_type word_kind(kbuf_type hb, len_type n);
      string w;
      w = "";
      if (n > len_type'(KEYWORD_CHARS)) return K_ID;
      for (int i = 0; i < n; i++) w = $sformatf("%s%c", w, hb[8*i +: 8]);
      case (w)
         "main":  return K_MAIN;
         "if":    return K_IF;
         "else":  return K_ELSE;
         "int":   return K_KWINT;
         "float": return K_KWFLT;
         "char":  return K_KWCHAR;
         "while": return K_WHILE;
         "do":    return K_DO;
         "for":   return K_FOR;
         default: return K_ID;
      endcase
   endfunction

   task automatic put_token(kind_type k, err_type e, pos_type ln, pos_type cl, len_type n);
      token_info_t t;
      if (step_tokens.size() >= 2) return;
      t.kind = k;
      t.err  = e;
      t.line = ln;
      t.col  = cl;
      t.len  = n;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic close_token(kind_type k, err_type e);
      put_token(k, e, tok_line, tok_col, tok_len);
   endtask

   task automatic keep_byte(logic [7:0] c);
      if (tok_len < len_type'(KEYWORD_CHARS)) head_bytes[8*tok_len +: 8] = c;
      if (tok_len < len_type'(MAX_LEXEME)) tok_len = tok_len + 1'b1;
   endtask

   task automatic open_token();
      tok_line   = cur_line;
      tok_col    = cur_col;
      tok_len    = '0;
      head_bytes = '0;
   endtask

   task automatic move_cursor(logic [7:0] c);
      logic [POSITION_WIDTH:0] sum;
      if (c == CH_NL) begin
         cur_col = '0;
         if (cur_line != POS_MAX) cur_line = cur_line + 1'b1;
      end else begin
         sum = {1'b0, cur_col} + ((c == CH_TAB) ? tab_cols : 4'd1);
         cur_col = (sum > POS_MAX) ? POS_MAX : sum[POSITION_WIDTH-1:0];
      end
   endtask

   // finish whatever token is open as if a separator came
   task automatic flush_open();
      case (sc)
         SC_IDENT:              close_token(word_kind(head_bytes, tok_len), E_NONE);
         SC_INT:                close_token(K_INT, E_NONE);
         SC_DOT:                close_token(K_ERROR, E_BAD_FLOAT);
         SC_FRAC:               close_token(K_FLOAT, E_NONE);
         SC_QUOTE:              close_token(K_ERROR, E_BAD_CHAR);
         SC_CHBODY:             close_token(K_ERROR, E_INVALID);
         SC_SLASH:              close_token(K_DIV, E_NONE);
         SC_BLKCOM, SC_BLKSTAR: close_token(K_ERROR, E_OPEN_COM);
         SC_EQ:                 close_token(K_ASSIGN, E_NONE);
         SC_LT:                 close_token(K_LT, E_NONE);
         SC_GT:                 close_token(K_GT, E_NONE);
         SC_BANG:               close_token(K_ERROR, E_BAD_BANG);
         default: ;
      endcase
      sc = SC_IDLE;
   endtask

   task automatic scan_char(logic [7:0] c);
      case (sc)
         SC_IDENT: if (letter_byte(c) || digit_byte(c) || (c == "_")) begin
            keep_byte(c);
            return;
         end
         SC_INT: begin
            if (digit_byte(c)) begin
               keep_byte(c);
               return;
            end
            if (c == ".") begin
               keep_byte(c);
               sc = SC_DOT;
               return;
            end
         end
         SC_DOT, SC_FRAC: if (digit_byte(c)) begin
            keep_byte(c);
            sc = SC_FRAC;
            return;
         end
         SC_QUOTE: if (letter_byte(c) || digit_byte(c)) begin
            keep_byte(c);
            sc = SC_CHBODY;
            return;
         end
         SC_CHBODY: if (c == "'") begin
            keep_byte(c);
            close_token(K_CHAR, E_NONE);
            sc = SC_IDLE;
            return;
         end
         SC_SLASH: begin
            if (c == "/") begin
               keep_byte(c);
               sc = SC_LINECOM;
               return;
            end
            if (c == "*") begin
               keep_byte(c);
               sc = SC_BLKCOM;
               return;
            end
         end
         SC_LINECOM: begin
            if (c == CH_NL) sc = SC_IDLE;
            return;
         end
         SC_BLKCOM: begin
            keep_byte(c);
            if (c == "*") sc = SC_BLKSTAR;
            return;
         end
         SC_BLKSTAR: begin
            keep_byte(c);
            if (c == "/") sc = SC_IDLE;
            else if (c != "*") sc = SC_BLKCOM;
            return;
         end
         SC_EQ, SC_LT, SC_GT: if (c == "=") begin
            keep_byte(c);
            close_token((sc == SC_EQ) ? K_EQEQ : (sc == SC_LT) ? K_LE : K_GE, E_NONE);
            sc = SC_IDLE;
            return;
         end
         SC_BANG: begin
            keep_byte(c);
            if (c == "=") close_token(K_NE, E_NONE);
            else close_token(K_ERROR, E_BAD_BANG);
            sc = SC_IDLE;
            return;
         end
         default: ;
      endcase
      // byte is not part of the open token: close it and rescan from idle
      flush_open();
      if (blank_byte(c)) return;
      open_token();
      keep_byte(c);
      if (letter_byte(c) || (c == "_")) sc = SC_IDENT;
      else if (digit_byte(c)) sc = SC_INT;
      else begin
         case (c)
            ".":     sc = SC_DOT;
            "'":     sc = SC_QUOTE;
            "/":     sc = SC_SLASH;
            "=":     sc = SC_EQ;
            "<":     sc = SC_LT;
            ">":     sc = SC_GT;
            "!":     sc = SC_BANG;
            "+":     close_token(K_PLUS, E_NONE);
            "-":     close_token(K_MINUS, E_NONE);
            "*":     close_token(K_STAR, E_NONE);
            "(":     close_token(K_LPAR, E_NONE);
            ")":     close_token(K_RPAR, E_NONE);
            "{":     close_token(K_LBRACE, E_NONE);
            "}":     close_token(K_RBRACE, E_NONE);
            ";":     close_token(K_SEMI, E_NONE);
            ",":     close_token(K_COMMA, E_NONE);
            default: close_token(K_ERROR, E_INVALID);
         endcase
      end
   endtask

   task automatic lex_byte(logic [7:0] c, logic eoi);
      token_info_t t;
      step_tokens.delete();
      if (eoi) begin
         flush_open();
         put_token(K_EOF, E_NONE, cur_line, cur_col, '0);
      end else begin
         move_cursor(c);
         scan_char(c);
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: token %0d %s mismatch, expected %0d, actual %0d",
                  $time, tokens_checked, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      token_info_t want;
      if (reset) begin
         sc         = SC_IDLE;
         cur_line   = pos_type'(1);
         cur_col    = '0;
         tok_line   = pos_type'(1);
         tok_col    = '0;
         head_bytes = '0;
         tok_len    = '0;
         tab_cols   = 4'd4;
         kinds_seen = '0;
         expected_tokens.delete();
      end else begin
         // compare before predicting: a token never leaves in the cycle of its byte
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected token, expected none, actual kind %0d line %0d col %0d",
                        $time, rsp_token_kind, rsp_token_line, rsp_token_column);
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("error_code", want.err, rsp_error_code);
               check_field("token_line", want.line, rsp_token_line);
               check_field("token_column", want.col, rsp_token_column);
               check_field("lexeme_length", want.len, rsp_lexeme_length);
               check_field("last_of_run", want.last, rsp_last_of_run);
               kinds_seen[rsp_token_kind] = 1'b1;
               tokens_checked++;
            end
         end
         if (csr_valid && csr_ready) tab_cols = csr_tab_width;
         if (req_valid && req_ready) lex_byte(req_char_code, req_end_of_input);
      end
      tokens_pending <= expected_tokens.size();
   end

endmodule

// ===== dv/source_lexer_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// source_lexer_tokenizer_tb: drives source bytes and tab width writes into the tokenizer
// and gives the verdict; slt_token_checker does all prediction and comparison
// depends on slt_pkg, source_lexer_tokenizer and slt_token_checker
module source_lexer_tokenizer_tb;

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam int PHASE_BYTES = 175;   // bytes per tab width setting
   localparam int LONG_HOLD   = 300;   // cycles the token sink refuses transactions once
   localparam int DRAIN_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   logic [7:0]                          req_char_code    = '0;
   logic                                req_end_of_input = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   logic [4:0]                          rsp_token_kind;
   logic [2:0]                          rsp_error_code;
   logic [slt_pkg::POSITION_WIDTH-1:0]  rsp_token_line;
   logic [slt_pkg::POSITION_WIDTH-1:0]  rsp_token_column;
   logic [slt_pkg::LEN_WIDTH-1:0]       rsp_lexeme_length;
   logic                                rsp_last_of_run;
   logic                                csr_valid        = 1'b0;
   logic                                csr_ready;
   logic [3:0]                          csr_tab_width    = 4'd0;

   int          mismatch_count;
   int          tokens_pending;
   int          tokens_checked;
   logic [31:0] kinds_seen;

   // stimulus knobs
   int   gap_odds      = 3;      // one byte in gap_odds is preceded by a sender gap, 0 = none
   logic rx_quiet      = 1'b0;   // sink accepts every cycle
   logic hold_off_go   = 1'b0;   // request the one long sink stall
   logic hold_off_done = 1'b0;
   int   bytes_sent    = 0;
   int   settings_used = 0;

   string kw_text [9]  = '{"main", "if", "else", "int", "float", "char", "while", "do", "for"};
   string op_text [17] = '{"+", "-", "*", "/", "=", "==", "<", "<=", ">", ">=", "!=",
                           "(", ")", "{", "}", ";", ","};

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   source_lexer_tokenizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_code    (rsp_error_code),
      .rsp_token_line    (rsp_token_line),
      .rsp_token_column  (rsp_token_column),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_tab_width     (csr_tab_width)
   );

   slt_token_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_code    (rsp_error_code),
      .rsp_token_line    (rsp_token_line),
      .rsp_token_column  (rsp_token_column),
      .rsp_lexeme_length (rsp_lexeme_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_tab_width     (csr_tab_width),
      .mismatch_count    (mismatch_count),
      .tokens_pending    (tokens_pending),
      .tokens_checked    (tokens_checked),
      .kinds_seen        (kinds_seen)
   );

   // ---------------------------------------------------------------------------
   // byte source helpers
   // ---------------------------------------------------------------------------

   // identifier character, a leading one never a digit
   function automatic logic [7:0] word_char(bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] digit_char();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0:       return " ";
         1:       return CH_TAB;
         2:       return CH_NL;
         3:       return 8'h0B;
         4:       return 8'h0C;
         default: return 8'h0D;
      endcase
   endfunction

   // comment body: heavy on stars and slashes so star runs and early closes happen
   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 5))
         0, 1:    return "*";
         2:       return "/";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one byte transaction; valid stays up across back-to-back transactions
   task automatic put_byte(logic [7:0] c, logic eoi);
      if ((gap_odds != 0) && ($urandom_range(1, gap_odds) == 1)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
   endtask

   task automatic put_alnum();
      logic [7:0] b;
      do b = word_char(1'b0); while (b == "_");
      put_byte(b, 1'b0);
   endtask

   // tab width write, only issued while no byte is being sent and no predicted token is pending
   task automatic write_tab(logic [3:0] w);
      csr_valid     <= 1'b1;
      csr_tab_width <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // stop sending, wait for every predicted token, then let a byte that
   // produced nothing settle inside the scanner
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while ((tokens_pending != 0) && (guard < DRAIN_LIMIT));
      repeat (4) @(posedge clock);
   endtask

   // one random piece of source text, mostly well formed, some noise and broken pieces
   task automatic put_fragment();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         // identifier, now and then longer than the lexeme length limit
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 8);
         put_byte(word_char(1'b1), 1'b0);
         repeat (n - 1) put_byte(word_char(1'b0), 1'b0);
      end else if (pick < 30) begin
         // keyword, sometimes spoiled by one more character
         put_text(kw_text[$urandom_range(0, 8)]);
         if ($urandom_range(0, 3) == 0) put_byte(word_char(1'b0), 1'b0);
      end else if (pick < 40) begin
         repeat ($urandom_range(1, 6)) put_byte(digit_char(), 1'b0);
      end else if (pick < 47) begin
         // float, with or without integer part
         repeat ($urandom_range(0, 3)) put_byte(digit_char(), 1'b0);
         put_byte(".", 1'b0);
         repeat ($urandom_range(1, 4)) put_byte(digit_char(), 1'b0);
      end else if (pick < 52) begin
         put_byte("'", 1'b0);
         put_alnum();
         put_byte("'", 1'b0);
      end else if (pick < 70) begin
         put_text(op_text[$urandom_range(0, 16)]);
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) put_byte(blank_char(), 1'b0);
      end else if (pick < 84) begin
         // line comment with arbitrary bytes
         put_text("//");
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL) b = "x";
            put_byte(b, 1'b0);
         end
         put_byte(CH_NL, 1'b0);
      end else if (pick < 89) begin
         put_text("/*");
         repeat ($urandom_range(0, 8)) put_byte(comment_char(), 1'b0);
         if ($urandom_range(0, 2) == 0) put_byte("*", 1'b0);
         put_text("*/");
      end else if (pick < 95) begin
         put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 98) begin
         // broken start followed by any byte
         case ($urandom_range(0, 3))
            0: put_byte(".", 1'b0);
            1: put_byte("'", 1'b0);
            2: put_byte("!", 1'b0);
            default: begin
               put_byte("'", 1'b0);
               put_alnum();
            end
         endcase
         put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         // end of input in the middle of the stream, byte value is don't care
         put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) put_byte(blank_char(), 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // token sink: random stall bursts, one long hold-off, quiet at the end
   // ---------------------------------------------------------------------------
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_go && !hold_off_done) begin
            // sink stalls long enough for the result queue to fill and back up the input
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
         repeat (n) @(posedge clock);
         if (!rx_quiet) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int         ph;
      int         phase_start;
      logic [3:0] tab_plan [6];

      // widest tab first so the directed text shows it, narrowest next
      tab_plan = '{4'd1, 4'd3, 4'd8, 4'd1, 4'd1, 4'd4};
      tab_plan[3] = 4'($urandom_range(1, 8));
      tab_plan[4] = 4'($urandom_range(1, 8));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_tab(4'd8);

      // directed text: invalid bytes at both ends of the range, bad bang,
      // bad float with the terminator rescanned, bad char, unclosed char,
      // block comment with a star run, lone bang and open comment at end of input
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_text("!x");
      put_text(".;");
      put_text("' ");
      put_text("'a+");
      put_text("/***/");
      put_text("\t!");
      put_byte(8'h00, 1'b1);
      put_text("/*");
      put_byte(8'hFF, 1'b1);
      put_byte(CH_NL, 1'b0);
      wait_drained();

      for (ph = 0; ph < 6; ph++) begin
         write_tab(tab_plan[ph]);
         case (ph)
            0:       gap_odds = 4;
            1:       gap_odds = 3;
            2:       gap_odds = 10;
            3:       gap_odds = 0;     // sender runs flat out, sink still stalls
            4:       gap_odds = 5;
            default: gap_odds = 0;
         endcase
         rx_quiet <= (ph == 5);
         if (ph == 1) hold_off_go <= 1'b1;
         if (ph == 0) begin
            // one identifier well past the lexeme length limit
            put_byte("q", 1'b0);
            repeat (69) put_byte(word_char(1'b0), 1'b0);
            put_byte(" ", 1'b0);
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) put_fragment();
         wait_drained();
      end

      $display("summary: %0d source bytes over %0d tab width writes, %0d tokens checked",
               bytes_sent, settings_used, tokens_checked);
      $display("summary: %0d of 32 token kinds seen, long sink hold-off %s",
               $countones(kinds_seen), hold_off_done ? "done" : "missed");
      if (tokens_pending != 0) $display("%0d predicted tokens never arrived", tokens_pending);
      if ((mismatch_count == 0) && (tokens_pending == 0)) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1500000;
      $display("watchdog expired after %0t ns", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
